### rtl/core/aalu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aalu_pkg
// Shared types and constants of the accumulator ALU: operation codes,
// decoded command classes and queue sizing.
// ----------------------------------------------------------------------------
package aalu_pkg;

    localparam int unsigned OP_W      = 5;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned IN_DATA_W = 16;
    localparam int unsigned OUT_DATA_W = 24;

    localparam logic [OP_W-1:0] OP_ADD      = 5'd0;
    localparam logic [OP_W-1:0] OP_ADC      = 5'd1;
    localparam logic [OP_W-1:0] OP_SUB      = 5'd2;
    localparam logic [OP_W-1:0] OP_SBB      = 5'd3;
    localparam logic [OP_W-1:0] OP_AND      = 5'd4;
    localparam logic [OP_W-1:0] OP_XOR      = 5'd5;
    localparam logic [OP_W-1:0] OP_OR       = 5'd6;
    localparam logic [OP_W-1:0] OP_CMP      = 5'd7;
    localparam logic [OP_W-1:0] OP_RLC      = 5'd8;
    localparam logic [OP_W-1:0] OP_RRC      = 5'd9;
    localparam logic [OP_W-1:0] OP_RAL      = 5'd10;
    localparam logic [OP_W-1:0] OP_RAR      = 5'd11;
    localparam logic [OP_W-1:0] OP_DAA      = 5'd12;
    localparam logic [OP_W-1:0] OP_CMA      = 5'd13;
    localparam logic [OP_W-1:0] OP_STC      = 5'd14;
    localparam logic [OP_W-1:0] OP_CMC      = 5'd15;
    localparam logic [OP_W-1:0] OP_INR      = 5'd16;
    localparam logic [OP_W-1:0] OP_DCR      = 5'd17;
    localparam logic [OP_W-1:0] OP_FLAGLOAD = 5'd18;
    localparam logic [OP_W-1:0] OP_ACCLOAD  = 5'd19;

    localparam logic [BYTE_W-1:0] DAA_LO_FIX = 8'h06;
    localparam logic [BYTE_W-1:0] DAA_HI_FIX = 8'h60;
    localparam logic [3:0]        BCD_NINE   = 4'd9;
    localparam logic [BYTE_W-1:0] STEP_UP    = 8'h01;
    localparam logic [BYTE_W-1:0] STEP_DOWN  = 8'hFE;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [3:0] {
        K_NOP,
        K_ADD,
        K_SUB,
        K_AND,
        K_XOR,
        K_OR,
        K_ROT,
        K_DAA,
        K_CMA,
        K_CY,
        K_STEP,
        K_FLAGLOAD,
        K_ACCLOAD
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               with_carry;
        logic               no_write;
        logic               right;
        logic               down;
        logic               toggle;
        logic [BYTE_W-1:0]  operand;
    } t_cmd;

endpackage

### rtl/core/accumulator_alu_with_flags.sv
`timescale 1ns / 1ps
// Each accepted word passes the decode register and the command queue to the output register.
// Throughput: one word per cycle while m_axis_tready is high; execute retires one command a cycle.
// The accumulator and flag registers feed back through combinational logic in the execute stage.
// Reset: synchronous, active low; clears accumulator, flags, queue and valid state.
// ----------------------------------------------------------------------------
// accumulator_alu_with_flags
// 8-bit accumulator ALU with sign, zero, aux carry, parity and carry flags;
// decode stage, command queue and execute stage.
// ----------------------------------------------------------------------------
module accumulator_alu_with_flags import aalu_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // op[4:0], operand[12:5], zero[15:13]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // acc_out[7:0], status_byte[15:8], stepped_value[23:16]
);

    logic w_f_valid;
    logic w_f_ready;
    t_cmd w_f_cmd;
    logic w_q_valid;
    logic w_q_ready;
    t_cmd w_q_cmd;

    aalu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tdata[OP_W-1:0]),
        .i_operand   (s_axis_tdata[OP_W+BYTE_W-1:OP_W]),
        .o_cmd_valid (w_f_valid),
        .i_cmd_ready (w_f_ready),
        .o_cmd       (w_f_cmd)
    );

    aalu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_cmd   (w_f_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_cmd    (w_q_cmd)
    );

    aalu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .i_cmd       (w_q_cmd),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata)
    );

endmodule

### rtl/core/aalu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aalu_front
// Input stage: take a word, classify the operation code and hold the
// decoded command until the queue takes it.
// ----------------------------------------------------------------------------
module aalu_front import aalu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [OP_W-1:0]   i_op,
    input  logic [BYTE_W-1:0] i_operand,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output t_cmd              o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    always_comb begin
        n_cmd            = '0;
        n_cmd.kind       = K_NOP;
        n_cmd.operand    = i_operand;
        case (i_op)
            OP_ADD: begin
                n_cmd.kind = K_ADD;
            end
            OP_ADC: begin
                n_cmd.kind       = K_ADD;
                n_cmd.with_carry = 1'b1;
            end
            OP_SUB: begin
                n_cmd.kind = K_SUB;
            end
            OP_SBB: begin
                n_cmd.kind       = K_SUB;
                n_cmd.with_carry = 1'b1;
            end
            OP_CMP: begin
                n_cmd.kind     = K_SUB;
                n_cmd.no_write = 1'b1;
            end
            OP_AND: n_cmd.kind = K_AND;
            OP_XOR: n_cmd.kind = K_XOR;
            OP_OR:  n_cmd.kind = K_OR;
            OP_RLC: n_cmd.kind = K_ROT;
            OP_RRC: begin
                n_cmd.kind  = K_ROT;
                n_cmd.right = 1'b1;
            end
            OP_RAL: begin
                n_cmd.kind       = K_ROT;
                n_cmd.with_carry = 1'b1;
            end
            OP_RAR: begin
                n_cmd.kind       = K_ROT;
                n_cmd.with_carry = 1'b1;
                n_cmd.right      = 1'b1;
            end
            OP_DAA: n_cmd.kind = K_DAA;
            OP_CMA: n_cmd.kind = K_CMA;
            OP_STC: n_cmd.kind = K_CY;
            OP_CMC: begin
                n_cmd.kind   = K_CY;
                n_cmd.toggle = 1'b1;
            end
            OP_INR: n_cmd.kind = K_STEP;
            OP_DCR: begin
                n_cmd.kind = K_STEP;
                n_cmd.down = 1'b1;
            end
            OP_FLAGLOAD: n_cmd.kind = K_FLAGLOAD;
            OP_ACCLOAD:  n_cmd.kind = K_ACCLOAD;
            default:     n_cmd.kind = K_NOP;
        endcase
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

### rtl/core/aalu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aalu_queue
// Short command queue between the decode stage and the execute stage.
// ----------------------------------------------------------------------------
module aalu_queue import aalu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + Q_CNT_W'(w_push) - Q_CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_count == $past(r_count) + Q_CNT_W'($past(w_push))
                            - Q_CNT_W'($past(w_pop)))
        else $error("queue fill count out of step with push and pop");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == Q_CNT_W'(Q_DEPTH) && !w_pop) |=> !o_push_ready)
        else $error("queue accepted a word while full");

    a_ptrs_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers differ while empty");

endmodule

### rtl/core/aalu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aalu_back
// Execute stage: accumulator and flag registers, the adder with flag logic,
// and the output register.
// ----------------------------------------------------------------------------
module aalu_back import aalu_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  t_cmd                  i_cmd,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_DATA_W-1:0] o_data
);

    logic [BYTE_W-1:0]     r_acc;
    logic                  r_cy;
    logic                  r_ac;
    logic                  r_z;
    logic                  r_s;
    logic                  r_p;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [BYTE_W-1:0] n_acc;
    logic              n_cy;
    logic              n_ac;
    logic              n_z;
    logic              n_s;
    logic              n_p;
    logic [BYTE_W-1:0] n_stepped;

    logic [BYTE_W-1:0] w_add_a;
    logic [BYTE_W-1:0] w_add_b;
    logic              w_add_cin;
    logic [BYTE_W:0]   w_sum;
    logic              w_sum_ac;
    logic [BYTE_W-1:0] w_res;
    logic              w_szp;
    logic              w_lo_gt9;
    logic              w_fix_lo;
    logic              w_fix_hi;
    logic              w_rot_in;
    logic              w_take;
    logic [BYTE_W-1:0] w_status;

    assign w_take      = i_cmd_valid && o_cmd_ready;
    assign o_cmd_ready = !r_out_valid || i_ready;

    assign w_lo_gt9 = (r_acc[3:0] > BCD_NINE);
    assign w_fix_lo = w_lo_gt9 || r_ac;
    assign w_fix_hi = (r_acc[7:4] > BCD_NINE) || r_cy || ((r_acc[7:4] == BCD_NINE) && w_lo_gt9);
    assign w_rot_in = i_cmd.with_carry ? r_cy : (i_cmd.right ? r_acc[0] : r_acc[7]);

    always_comb begin
        w_add_a   = r_acc;
        w_add_b   = i_cmd.operand;
        w_add_cin = 1'b0;
        case (i_cmd.kind)
            K_ADD: begin
                w_add_cin = i_cmd.with_carry && r_cy;
            end
            K_SUB: begin
                w_add_b   = ~i_cmd.operand;
                w_add_cin = !(i_cmd.with_carry && r_cy);
            end
            K_DAA: begin
                w_add_b = (w_fix_lo ? DAA_LO_FIX : '0) | (w_fix_hi ? DAA_HI_FIX : '0);
            end
            K_STEP: begin
                w_add_a   = i_cmd.operand;
                w_add_b   = i_cmd.down ? STEP_DOWN : STEP_UP;
                w_add_cin = i_cmd.down;
            end
            default: begin
                w_add_cin = 1'b0;
            end
        endcase
    end

    assign w_sum    = {1'b0, w_add_a} + {1'b0, w_add_b} + {{BYTE_W{1'b0}}, w_add_cin};
    assign w_sum_ac = w_add_a[4] ^ w_add_b[4] ^ w_sum[4];

    always_comb begin
        n_acc     = r_acc;
        n_cy      = r_cy;
        n_ac      = r_ac;
        n_z       = r_z;
        n_s       = r_s;
        n_p       = r_p;
        w_res     = w_sum[BYTE_W-1:0];
        w_szp     = 1'b0;
        case (i_cmd.kind)
            K_ADD: begin
                n_acc = w_sum[BYTE_W-1:0];
                n_cy  = w_sum[BYTE_W];
                n_ac  = w_sum_ac;
                w_szp = 1'b1;
            end
            K_SUB: begin
                if (!i_cmd.no_write) begin
                    n_acc = w_sum[BYTE_W-1:0];
                end
                n_cy  = !w_sum[BYTE_W];
                n_ac  = w_sum_ac;
                w_szp = 1'b1;
            end
            K_AND: begin
                w_res = r_acc & i_cmd.operand;
                n_acc = w_res;
                n_ac  = r_acc[3] | i_cmd.operand[3];
                n_cy  = 1'b0;
                w_szp = 1'b1;
            end
            K_XOR: begin
                w_res = r_acc ^ i_cmd.operand;
                n_acc = w_res;
                n_ac  = 1'b0;
                n_cy  = 1'b0;
                w_szp = 1'b1;
            end
            K_OR: begin
                w_res = r_acc | i_cmd.operand;
                n_acc = w_res;
                n_ac  = 1'b0;
                n_cy  = 1'b0;
                w_szp = 1'b1;
            end
            K_ROT: begin
                if (i_cmd.right) begin
                    n_acc = {w_rot_in, r_acc[7:1]};
                    n_cy  = r_acc[0];
                end else begin
                    n_acc = {r_acc[6:0], w_rot_in};
                    n_cy  = r_acc[7];
                end
            end
            K_DAA: begin
                n_acc = w_sum[BYTE_W-1:0];
                n_cy  = r_cy || w_fix_hi;
                n_ac  = w_sum_ac;
                w_szp = 1'b1;
            end
            K_CMA: begin
                n_acc = ~r_acc;
            end
            K_CY: begin
                n_cy = i_cmd.toggle ? !r_cy : 1'b1;
            end
            K_STEP: begin
                n_ac  = w_sum_ac;
                w_szp = 1'b1;
            end
            K_FLAGLOAD: begin
                n_s  = i_cmd.operand[7];
                n_z  = i_cmd.operand[6];
                n_ac = i_cmd.operand[4];
                n_p  = i_cmd.operand[2];
                n_cy = i_cmd.operand[0];
            end
            K_ACCLOAD: begin
                n_acc = i_cmd.operand;
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
        if (w_szp) begin
            n_z = (w_res == '0);
            n_s = w_res[7];
            n_p = ~^w_res;
        end
        n_stepped = (i_cmd.kind == K_STEP) ? w_sum[BYTE_W-1:0] : n_acc;
    end

    assign w_status = {n_s, n_z, 1'b0, n_ac, 1'b0, n_p, 1'b1, n_cy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cy        <= 1'b0;
            r_ac        <= 1'b0;
            r_z         <= 1'b0;
            r_s         <= 1'b0;
            r_p         <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_acc <= n_acc;
                r_cy  <= n_cy;
                r_ac  <= n_ac;
                r_z   <= n_z;
                r_s   <= n_s;
                r_p   <= n_p;
            end
            if (o_cmd_ready) begin
                r_out_valid <= i_cmd_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_data <= {n_stepped, w_status, n_acc};
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    a_no_take_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !w_take)
        else $error("command taken while result word stalled");

    a_take_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_out_valid)
        else $error("taken command produced no result word");

    a_cmp_keeps_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_cmd.kind == K_SUB && i_cmd.no_write) |=> r_acc == $past(r_acc))
        else $error("compare altered the accumulator");

    a_idle_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_take |=> $stable(r_acc) && $stable(r_cy))
        else $error("accumulator or carry changed without a command");

endmodule
